// File: rtl/core/ehj_pkg.sv
// shared types and constants for the equality hash join engine
package ehj_pkg;

   localparam int KEY_W        = 64;
   localparam int ROW_W        = 32;
   localparam int SLOT_BITS    = 8;
   localparam int KEY_SLOTS    = 1 << SLOT_BITS;
   localparam int ROW_SEL_BITS = 4;
   localparam int MAX_ROWS     = 1 << ROW_SEL_BITS;
   localparam int CNT_BITS     = ROW_SEL_BITS + 1;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 3;

   localparam logic [KIND_W-1:0] KIND_BUILD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROBE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_BUILD,
      OP_PROBE,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_MATCH    = 3'd1,
      ST_NOMATCH  = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [ROW_W-1:0]     row_id;
      logic [SLOT_BITS-1:0] hash;
   } item_type;

   typedef struct packed {
      status_type       status;
      logic [ROW_W-1:0] probe_row;
      logic [ROW_W-1:0] build_row;
      logic             last;
   } result_type;

   // fold the key down to a slot index
   function automatic logic [SLOT_BITS-1:0] key_hash(input logic [KEY_W-1:0] key);
      logic [SLOT_BITS-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W / SLOT_BITS; i++) begin
         h = h ^ key[i*SLOT_BITS +: SLOT_BITS];
      end
      return h;
   endfunction

endpackage

// File: rtl/core/equi_hash_join_engine_top.sv
// top level of the equality hash join engine
// the front queue registers each item for the back end, which probes slots linearly from the key
// hash through S_READ and S_CMP per slot and emits each match pair through S_MREAD and S_MEMIT,
// steps set by the registered table memory reads; a clear is answered straight from idle
// one item at a time in the back end, which takes the next only when back in idle
// reset: queues, sequencer and slot valid bits clear at once; table memories are not cleared
module equi_hash_join_engine_top import ehj_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [ROW_W-1:0]    req_row_id,
   output logic                empty,
   input  logic                pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ROW_W-1:0]    rsp_probe_row,
   output logic [ROW_W-1:0]    rsp_build_row,
   output logic                rsp_last
);

   logic       fe_valid, fe_take, rsp_full, res_valid;
   item_type   fe_item;
   result_type res;

   // intake and classification
   ehj_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_kind(req_kind), .req_key(req_key), .req_row_id(req_row_id),
      .fe_valid(fe_valid), .fe_item(fe_item), .fe_take(fe_take)
   );

   // table work
   ehj_back u_back (
      .clock(clock), .reset(reset), .fe_valid(fe_valid), .fe_item(fe_item),
      .fe_take(fe_take), .rsp_full(rsp_full), .res_valid(res_valid), .res(res)
   );

   // result queue
   ehj_rsp_q u_rsp_q (
      .clock(clock), .reset(reset), .res_valid(res_valid), .res(res),
      .rsp_full(rsp_full), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_probe_row(rsp_probe_row),
      .rsp_build_row(rsp_build_row), .rsp_last(rsp_last)
   );

endmodule

// File: rtl/core/ehj_front.sv
// front end: accepts items, classifies them and queues them for the back end
module ehj_front import ehj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [ROW_W-1:0]  req_row_id,
   output logic              fe_valid,
   output item_type          fe_item,
   input  logic              fe_take
);

   item_type   q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   item_type   cls;

   // classify the incoming item
   always_comb begin
      unique case (req_kind)
         KIND_BUILD: cls.op = OP_BUILD;
         KIND_PROBE: cls.op = OP_PROBE;
         KIND_CLEAR: cls.op = OP_CLEAR;
         default:    cls.op = OP_NONE;
      endcase
      cls.key    = req_key;
      cls.row_id = req_row_id;
      cls.hash   = key_hash(req_key);
   end

   assign full     = (cnt_ff == 2'd2);
   assign fe_valid = (cnt_ff != 2'd0);
   assign fe_item  = q_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = fe_take && fe_valid;

   // queue pointers
   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

// File: rtl/core/ehj_back.sv
// back end: probes the key table, updates it and produces results
module ehj_back import ehj_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fe_valid,
   input  item_type   fe_item,
   output logic       fe_take,
   input  logic       rsp_full,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_MREAD,
      S_MEMIT
   } state_type;

   state_type             state_ff;
   item_type              cur_ff;
   logic [SLOT_BITS-1:0]  idx_ff;
   logic [SLOT_BITS-1:0]  step_ff;
   logic [ROW_SEL_BITS-1:0] j_ff;
   logic [CNT_BITS-1:0]   n_ff;
   logic [KEY_SLOTS-1:0]  used_ff;

   logic [KEY_W-1:0]      key_mem [KEY_SLOTS];
   logic [CNT_BITS-1:0]   cnt_mem [KEY_SLOTS];
   logic [ROW_W-1:0]      row_mem [KEY_SLOTS*MAX_ROWS];
   logic [KEY_W-1:0]      key_rd_ff;
   logic [CNT_BITS-1:0]   cnt_rd_ff;
   logic [ROW_W-1:0]      row_rd_ff;

   logic slot_free, slot_hit, all_probed, pair_last;
   logic key_we, cnt_we, row_we;
   logic [CNT_BITS-1:0] cnt_wd;
   logic [ROW_SEL_BITS-1:0] row_wsel;

   assign slot_free  = !used_ff[idx_ff];
   assign slot_hit   = used_ff[idx_ff] && (key_rd_ff == cur_ff.key);
   assign all_probed = (step_ff == {SLOT_BITS{1'b1}});
   assign pair_last  = ({1'b0, j_ff} + CNT_BITS'(1)) == n_ff;
   assign fe_take    = (state_ff == S_IDLE) && !rsp_full;

   // result and table write decisions
   always_comb begin
      res_valid     = 1'b0;
      res.status    = ST_INSERTED;
      res.probe_row = '0;
      res.build_row = '0;
      res.last      = 1'b1;
      key_we        = 1'b0;
      cnt_we        = 1'b0;
      row_we        = 1'b0;
      cnt_wd        = CNT_BITS'(1);
      row_wsel      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (fe_valid && !rsp_full && fe_item.op == OP_CLEAR) begin
               res_valid  = 1'b1;
               res.status = ST_CLEARED;
            end
         end
         S_CMP: begin
            if (!rsp_full) begin
               if (cur_ff.op == OP_BUILD) begin
                  res.build_row = cur_ff.row_id;
                  if (slot_free) begin
                     res_valid = 1'b1;
                     key_we    = 1'b1;
                     cnt_we    = 1'b1;
                     row_we    = 1'b1;
                  end else if (slot_hit) begin
                     res_valid = 1'b1;
                     if (cnt_rd_ff < CNT_BITS'(MAX_ROWS)) begin
                        cnt_we   = 1'b1;
                        cnt_wd   = cnt_rd_ff + CNT_BITS'(1);
                        row_we   = 1'b1;
                        row_wsel = cnt_rd_ff[ROW_SEL_BITS-1:0];
                     end else begin
                        res.status = ST_DROPPED;
                     end
                  end else if (all_probed) begin
                     res_valid  = 1'b1;
                     res.status = ST_DROPPED;
                  end
               end else begin
                  if (slot_free || (all_probed && !slot_hit) ||
                      (slot_hit && cnt_rd_ff == '0)) begin
                     res_valid  = 1'b1;
                     res.status = ST_NOMATCH;
                  end
               end
            end
         end
         S_MEMIT: begin
            if (!rsp_full) begin
               res_valid     = 1'b1;
               res.status    = ST_MATCH;
               res.probe_row = cur_ff.row_id;
               res.build_row = row_rd_ff;
               res.last      = pair_last;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (fe_take && fe_valid) begin
                  cur_ff  <= fe_item;
                  idx_ff  <= fe_item.hash;
                  step_ff <= '0;
                  priority case (fe_item.op)
                     OP_CLEAR: used_ff <= '0;
                     OP_BUILD, OP_PROBE: state_ff <= S_READ;
                     default: ;
                  endcase
               end
            end
            S_READ: state_ff <= S_CMP;
            S_CMP: begin
               if (!rsp_full) begin
                  if (key_we) begin
                     used_ff[idx_ff] <= 1'b1;
                  end
                  if (res_valid) begin
                     state_ff <= S_IDLE;
                  end else if (slot_hit) begin
                     n_ff     <= cnt_rd_ff;
                     j_ff     <= '0;
                     state_ff <= S_MREAD;
                  end else begin
                     idx_ff   <= idx_ff + SLOT_BITS'(1);
                     step_ff  <= step_ff + SLOT_BITS'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            S_MREAD: state_ff <= S_MEMIT;
            S_MEMIT: begin
               if (!rsp_full) begin
                  if (pair_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     j_ff     <= j_ff + ROW_SEL_BITS'(1);
                     state_ff <= S_MREAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // key table memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[idx_ff] <= cur_ff.key;
      end
      if (cnt_we) begin
         cnt_mem[idx_ff] <= cnt_wd;
      end
      if (row_we) begin
         row_mem[{idx_ff, row_wsel}] <= cur_ff.row_id;
      end
      key_rd_ff <= key_mem[idx_ff];
      cnt_rd_ff <= cnt_mem[idx_ff];
      row_rd_ff <= row_mem[{idx_ff, j_ff}];
   end

endmodule

// File: rtl/core/ehj_rsp_q.sv
// result queue between the back end and the result ports
module ehj_rsp_q import ehj_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  result_type          res,
   output logic                rsp_full,
   output logic                empty,
   input  logic                pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ROW_W-1:0]    rsp_probe_row,
   output logic [ROW_W-1:0]    rsp_build_row,
   output logic                rsp_last
);

   result_type q_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       do_push, do_pop;
   result_type head;

   assign rsp_full = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign do_push  = res_valid && !rsp_full;
   assign do_pop   = pop && !empty;
   assign head     = q_ff[rd_ff];

   assign rsp_status    = head.status;
   assign rsp_probe_row = head.probe_row;
   assign rsp_build_row = head.build_row;
   assign rsp_last      = head.last;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + 3'(do_push) - 3'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= res;
      end
   end

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the equality hash join engine
module tb_top;
   import ehj_pkg::*;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [ROW_W-1:0]  row_id;
      bit                typed;
      status_type        status;
      logic [ROW_W-1:0]  probe_row;
      logic [ROW_W-1:0]  build_row;
   } stim_type;

   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic [KIND_W-1:0]   req_kind;
   logic [KEY_W-1:0]    req_key;
   logic [ROW_W-1:0]    req_row_id;
   logic                empty;
   logic                pop;
   logic [STATUS_W-1:0] rsp_status;
   logic [ROW_W-1:0]    rsp_probe_row;
   logic [ROW_W-1:0]    rsp_build_row;
   logic                rsp_last;

   // own copy of the key table
   logic [KEY_W-1:0]    tbl_key [KEY_SLOTS];
   bit                  tbl_used [KEY_SLOTS];
   int                  tbl_count [KEY_SLOTS];
   logic [ROW_W-1:0]    tbl_rows [KEY_SLOTS][MAX_ROWS];

   result_type          pending_q[$];
   result_type          join_out[$];
   stim_type            directed[$];
   int                  errors;
   bit                  no_stall;

   equi_hash_join_engine_top uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_kind(req_kind), .req_key(req_key), .req_row_id(req_row_id),
      .empty(empty), .pop(pop), .rsp_status(rsp_status),
      .rsp_probe_row(rsp_probe_row), .rsp_build_row(rsp_build_row), .rsp_last(rsp_last)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic result_type mk(status_type st, logic [ROW_W-1:0] pr,
                                     logic [ROW_W-1:0] br, logic lst);
      result_type r;
      r.status = st;
      r.probe_row = pr;
      r.build_row = br;
      r.last = lst;
      return r;
   endfunction

   // expected results of one item, table updated
   task automatic join_predict(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [ROW_W-1:0] rid);
      int s;
      join_out.delete();
      s = -1;
      for (int i = 0; i < KEY_SLOTS; i++)
         if (s < 0 && tbl_used[i] && tbl_key[i] == key) s = i;
      case (kind)
         KIND_BUILD: begin
            if (s < 0) begin
               for (int i = 0; i < KEY_SLOTS; i++)
                  if (s < 0 && !tbl_used[i]) s = i;
               if (s >= 0) begin
                  tbl_used[s] = 1;
                  tbl_key[s] = key;
                  tbl_count[s] = 0;
               end
            end
            if (s < 0 || tbl_count[s] >= MAX_ROWS) begin
               join_out = {join_out, mk(ST_DROPPED, '0, rid, 1'b1)};
            end else begin
               tbl_rows[s][tbl_count[s]] = rid;
               tbl_count[s]++;
               join_out = {join_out, mk(ST_INSERTED, '0, rid, 1'b1)};
            end
         end
         KIND_PROBE: begin
            if (s < 0 || tbl_count[s] == 0)
               join_out = {join_out, mk(ST_NOMATCH, '0, '0, 1'b1)};
            else
               for (int j = 0; j < tbl_count[s]; j++)
                  join_out = {join_out, mk(ST_MATCH, rid, tbl_rows[s][j],
                                           j == tbl_count[s] - 1)};
         end
         KIND_CLEAR: begin
            for (int i = 0; i < KEY_SLOTS; i++) tbl_used[i] = 0;
            join_out = {join_out, mk(ST_CLEARED, '0, '0, 1'b1)};
         end
         default: ;
      endcase
   endtask

   // send one item with a random gap, keeping push high across back-to-back items
   task automatic send_item(stim_type r);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= r.kind;
      req_key <= r.key;
      req_row_id <= r.row_id;
      do @(posedge clock); while (full);
      join_predict(r.kind, r.key, r.row_id);
      if (r.typed)
         pending_q = {pending_q, mk(r.status, r.probe_row, r.build_row, 1'b1)};
      else
         pending_q = {pending_q, join_out};
   endtask

   function automatic stim_type item(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                                     logic [ROW_W-1:0] rid);
      stim_type r;
      r.kind = k;
      r.key = key;
      r.row_id = rid;
      r.typed = 0;
      r.status = ST_INSERTED;
      r.probe_row = '0;
      r.build_row = '0;
      return r;
   endfunction

   function automatic stim_type known(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                                      logic [ROW_W-1:0] rid, status_type st,
                                      logic [ROW_W-1:0] pr, logic [ROW_W-1:0] br);
      stim_type r;
      r = item(k, key, rid);
      r.typed = 1;
      r.status = st;
      r.probe_row = pr;
      r.build_row = br;
      return r;
   endfunction

   // append one row to the directed table
   task automatic add_row(stim_type r);
      directed = {directed, r};
   endtask

   // result side: random pop stalls, compare against oldest expectation
   initial begin
      int stall;
      result_type want;
      pop = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_stall ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         if (pending_q.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d probe %h build %h last %b",
                     $time, rsp_status, rsp_probe_row, rsp_build_row, rsp_last);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_probe_row !== want.probe_row) begin
               $display("%0t: probe_row expected %h actual %h",
                        $time, want.probe_row, rsp_probe_row);
               errors++;
            end
            if (rsp_build_row !== want.build_row) begin
               $display("%0t: build_row expected %h actual %h",
                        $time, want.build_row, rsp_build_row);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [KEY_W-1:0] pool [8];
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] base;
      int pick;
      int waited;
      errors = 0;
      no_stall = 0;
      reset = 1'b1;
      push = 1'b0;
      req_kind = '0;
      req_key = '0;
      req_row_id = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         tbl_used[i] = 0;
         tbl_count[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every kind, unknown kind, clear, misses
      add_row(known(KIND_PROBE, '0, 32'h1234, ST_NOMATCH, '0, '0));
      add_row(known(KIND_BUILD, '1, '1, ST_INSERTED, '0, '1));
      add_row(known(KIND_BUILD, '0, '0, ST_INSERTED, '0, '0));
      add_row(item(KIND_PROBE, '1, '0));
      add_row(item(KIND_PROBE, '0, '1));
      add_row(item(KIND_BUILD, '1, 32'h5555_aaaa));
      add_row(item(KIND_BUILD, '1, 32'haaaa_5555));
      add_row(item(KIND_PROBE, '1, 32'h0f0f_f0f0));
      add_row(item(KIND_NONE, '1, '1));
      add_row(item(KIND_NONE, '0, '0));
      // same hash as all-ones, different key
      add_row(item(KIND_BUILD, 64'hfefe_ffff_ffff_ffff, 32'h77));
      add_row(item(KIND_PROBE, 64'hfefe_ffff_ffff_ffff, 32'h88));
      add_row(known(KIND_PROBE, 64'h0123_4567_89ab_cdef, '1, ST_NOMATCH, '0, '0));
      add_row(known(KIND_CLEAR, '1, '1, ST_CLEARED, '0, '0));
      add_row(known(KIND_PROBE, '1, '1, ST_NOMATCH, '0, '0));
      add_row(known(KIND_PROBE, '0, '0, ST_NOMATCH, '0, '0));
      add_row(known(KIND_BUILD, '1, 32'h1, ST_INSERTED, '0, 32'h1));
      add_row(item(KIND_PROBE, '1, 32'h2));
      add_row(known(KIND_CLEAR, '0, '0, ST_CLEARED, '0, '0));
      foreach (directed[i]) send_item(directed[i]);

      // random: small key pool with hash collisions, mostly builds and probes
      for (int i = 0; i < 8; i++) begin
         base = {$urandom, $urandom};
         pool[i] = (i % 2) ? (pool[i-1] ^ 64'h0101_0000_0000_0000) : base;
      end
      for (int n = 0; n < 70; n++) begin
         if (n % 40 == 0) no_stall = ~no_stall;
         pick = $urandom_range(0, 99);
         key = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : pool[$urandom_range(0, 7)];
         if (pick < 50)      send_item(item(KIND_BUILD, key, $urandom));
         else if (pick < 88) send_item(item(KIND_PROBE, key, $urandom));
         else if (pick < 94) send_item(item(KIND_CLEAR, {$urandom, $urandom}, $urandom));
         else                send_item(item(KIND_NONE, {$urandom, $urandom}, $urandom));
      end
      no_stall = 0;

      // row list overflow on two keys
      for (int t = 0; t < 2; t++) begin
         key = {$urandom, $urandom};
         for (int j = 0; j <= MAX_ROWS; j++) send_item(item(KIND_BUILD, key, $urandom));
         send_item(item(KIND_PROBE, key, $urandom));
      end
      push <= 1'b0;

      // drain
      waited = 0;
      while (pending_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_q.size() != 0) begin
         $display("%0t: %0d expected results never came", $time, pending_q.size());
         errors++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
